>>> hw/rtl/bpr_pkg.sv
// shared constants and codes for the buffer pool replacement block
package bpr_pkg;

  // default sizes of the slot table
  localparam int SLOT_COUNT_DEF = 32;
  localparam int AGE_BITS_DEF   = 16;
  localparam int TAG_BITS_DEF   = 16;

  // fixed field widths
  localparam int OP_W    = 2;
  localparam int BLOCK_W = 16;
  localparam int COUNT_W = 17;
  localparam int STAT_W  = 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 17'd8192;

  // request opcodes (the unused code behaves as a lookup)
  localparam logic [OP_W-1:0] OP_LOOKUP     = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK_DIRTY = 2'd1;
  localparam logic [OP_W-1:0] OP_ALLOCATE   = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_SUCCESS   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOB       = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

endpackage

>>> hw/rtl/bpr_cell.sv
// one buffer slot of the replacement chain: slot state plus one stage of the sweep
module bpr_cell #(
  parameter int  AGE_BITS = bpr_pkg::AGE_BITS_DEF,
  parameter int  TAG_BITS = bpr_pkg::TAG_BITS_DEF,
  parameter int  IDX_W    = 5,
  parameter int  INDEX    = 0,
  parameter type carry_t  = logic,
  parameter type wcmd_t   = logic
) (
  input  logic   clk,
  input  logic   rst,
  input  carry_t carry_in,
  output carry_t carry_out,
  input  wcmd_t  wcmd
);

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
  localparam logic [IDX_W-1:0]    MY_IDX  = IDX_W'(INDEX);

  logic                occ;
  logic                dirty;
  logic [TAG_BITS-1:0] tag;
  logic [AGE_BITS-1:0] age;

  logic [AGE_BITS-1:0] aged;
  logic                is_alloc;
  carry_t              carry_next;

  assign aged     = (age == AGE_MAX) ? age : age + 1'b1;
  assign is_alloc = (carry_in.op == bpr_pkg::OP_ALLOCATE);

  always_comb begin
    carry_next = carry_in;
    if (carry_in.valid) begin
      if (is_alloc) begin
        // lowest free slot
        if (!carry_in.hit_found && !occ) begin
          carry_next.hit_found = 1'b1;
          carry_next.hit_idx   = MY_IDX;
        end
        // oldest occupied slot after aging, strict compare keeps the lowest
        if (occ && (aged > carry_in.max_age)) begin
          carry_next.max_age   = aged;
          carry_next.max_idx   = MY_IDX;
          carry_next.max_dirty = dirty;
          carry_next.max_tag   = tag;
        end
      end else if (!carry_in.hit_found && occ && (tag == carry_in.tag)) begin
        carry_next.hit_found = 1'b1;
        carry_next.hit_idx   = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out <= '0;
    end else begin
      carry_out <= carry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ   <= 1'b0;
      dirty <= 1'b0;
    end else if (wcmd.en && (wcmd.idx == MY_IDX)) begin
      if (wcmd.fill) begin
        occ   <= 1'b1;
        dirty <= 1'b0;
      end else begin
        dirty <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wcmd.en && wcmd.fill && (wcmd.idx == MY_IDX)) begin
      tag <= wcmd.tag;
      age <= '0;
    end else if (carry_in.valid && is_alloc && occ) begin
      age <= aged;
    end
  end

endmodule

>>> hw/rtl/buffer_pool_replacement.sv
// buffer slot manager with timestamp lru replacement, built as a chain of slot cells
//
//  channel   signals                                  direction  handshake
//  -------   ---------------------------------------  ---------  -------------------------
//  request   start, busy, opcode, block_num            in         word taken when start & !busy
//  result    done, status, slot, writeback_valid/block out        one cycle strobe on done
//  config    cfg_valid, cfg_ready, cfg_data            in         word taken when valid & ready
//
//  an in-bound request goes into the launch register and then through the register of
//  each cell in turn as the request word walks down the chain; done and the result are
//  registered from the word that leaves the last cell. the chosen cell is written at the edge
//  that ends the done cycle, so the next request is taken only after that write.
//  an out-of-bound request skips the chain and raises done in the cycle after accept.
//  busy stays high from accept until the done cycle ends; one request is in flight.
//  the result side cannot stall, so done is never held.
//  reset (synchronous) frees every slot and loads the block count with 8192.
module buffer_pool_replacement #(
  parameter int SLOT_COUNT = bpr_pkg::SLOT_COUNT_DEF,
  parameter int AGE_BITS   = bpr_pkg::AGE_BITS_DEF,
  parameter int TAG_BITS   = bpr_pkg::TAG_BITS_DEF,
  localparam int IDX_W     = $clog2(SLOT_COUNT)
) (
  input  logic                        clk,
  input  logic                        rst,
  // request
  input  logic                        start,
  output logic                        busy,
  input  logic [bpr_pkg::OP_W-1:0]    opcode,
  input  logic [bpr_pkg::BLOCK_W-1:0] block_num,
  // result
  output logic                        done,
  output logic [bpr_pkg::STAT_W-1:0]  status,
  output logic [IDX_W-1:0]            slot,
  output logic                        writeback_valid,
  output logic [bpr_pkg::BLOCK_W-1:0] writeback_block,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bpr_pkg::COUNT_W-1:0] cfg_data
);

  // request word travelling down the chain with the running search results
  typedef struct packed {
    logic                     valid;
    logic [bpr_pkg::OP_W-1:0] op;
    logic [TAG_BITS-1:0]      tag;
    logic                     hit_found;  // free slot on allocate, match otherwise
    logic [IDX_W-1:0]         hit_idx;
    logic [AGE_BITS-1:0]      max_age;
    logic [IDX_W-1:0]         max_idx;
    logic                     max_dirty;
    logic [TAG_BITS-1:0]      max_tag;
  } carry_t;

  // write broadcast to all cells, the cell with the matching index takes it
  typedef struct packed {
    logic                en;
    logic                fill;  // fill clean with age 0, else set dirty
    logic [IDX_W-1:0]    idx;
    logic [TAG_BITS-1:0] tag;
  } wcmd_t;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_DONE  = 2'd2;

  logic [1:0]                  state;
  logic [bpr_pkg::COUNT_W-1:0] block_count;
  carry_t                      chain [SLOT_COUNT+1];
  carry_t                      inject;
  carry_t                      tail;
  wcmd_t                       wcmd;

  logic accept;
  logic out_of_bound;

  assign cfg_ready    = 1'b1;
  assign busy         = (state != S_IDLE);
  assign done         = (state == S_DONE);
  assign accept       = start && !busy;
  // block count above the block range puts every block in bound, zero puts none
  assign out_of_bound = ({1'b0, block_num} >= block_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= bpr_pkg::COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      block_count <= cfg_data;
    end
  end

  // launch register feeding the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      inject <= '0;
    end else begin
      inject.valid     <= accept && !out_of_bound;
      inject.op        <= opcode;
      inject.tag       <= TAG_BITS'(block_num);
      inject.hit_found <= 1'b0;
      inject.hit_idx   <= '0;
      inject.max_age   <= '0;
      inject.max_idx   <= '0;
      inject.max_dirty <= 1'b0;
      inject.max_tag   <= '0;
    end
  end

  assign chain[0] = inject;
  assign tail     = chain[SLOT_COUNT];

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    bpr_cell #(
      .AGE_BITS (AGE_BITS),
      .TAG_BITS (TAG_BITS),
      .IDX_W    (IDX_W),
      .INDEX    (i),
      .carry_t  (carry_t),
      .wcmd_t   (wcmd_t)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .carry_in  (chain[i]),
      .carry_out (chain[i+1]),
      .wcmd      (wcmd)
    );
  end

  // sequencer: launch, wait for the word to leave the last cell, then answer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      wcmd.en <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          wcmd.en <= 1'b0;
          if (accept) begin
            state <= out_of_bound ? S_DONE : S_SWEEP;
          end
        end
        S_SWEEP: begin
          // allocate always fills, mark dirty writes only on a hit
          wcmd.en <= tail.valid && ((tail.op == bpr_pkg::OP_ALLOCATE) ||
                                    (tail.hit_found && (tail.op == bpr_pkg::OP_MARK_DIRTY)));
          if (tail.valid) begin
            state    <= S_DONE;
            wcmd.tag <= tail.tag;
            if (tail.op == bpr_pkg::OP_ALLOCATE) begin
              wcmd.fill <= 1'b1;
              wcmd.idx  <= tail.hit_found ? tail.hit_idx : tail.max_idx;
            end else begin
              wcmd.fill <= 1'b0;
              wcmd.idx  <= tail.hit_idx;
            end
          end
        end
        S_DONE: begin
          wcmd.en <= 1'b0;
          state   <= S_IDLE;
        end
        default: begin
          wcmd.en <= 1'b0;
          state   <= S_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && out_of_bound) begin
      status          <= bpr_pkg::STAT_OOB;
      slot            <= '0;
      writeback_valid <= 1'b0;
      writeback_block <= '0;
    end else if ((state == S_SWEEP) && tail.valid) begin
      if (tail.op == bpr_pkg::OP_ALLOCATE) begin
        // free slot wins, otherwise evict the oldest
        status          <= bpr_pkg::STAT_SUCCESS;
        slot            <= tail.hit_found ? tail.hit_idx : tail.max_idx;
        writeback_valid <= !tail.hit_found && tail.max_dirty;
        writeback_block <= (!tail.hit_found && tail.max_dirty) ?
                           bpr_pkg::BLOCK_W'(tail.max_tag) : '0;
      end else begin
        status          <= tail.hit_found ? bpr_pkg::STAT_SUCCESS : bpr_pkg::STAT_NOT_FOUND;
        slot            <= tail.hit_found ? tail.hit_idx : '0;
        writeback_valid <= 1'b0;
        writeback_block <= '0;
      end
    end
  end

endmodule

>>> test/tb_buffer_pool_replacement.sv
// testbench for the buffer pool replacement block: predicted answers checked at each done strobe
`timescale 1ns / 100ps

module tb_buffer_pool_replacement;

  localparam int SLOTS  = bpr_pkg::SLOT_COUNT_DEF;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int AGE_W  = bpr_pkg::AGE_BITS_DEF;
  localparam int TAG_W  = bpr_pkg::TAG_BITS_DEF;

  // the package leaves the fourth code unnamed; the block treats it as a lookup
  localparam logic [bpr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [AGE_W-1:0] AGE_TOP = '1;

  // quiet cycles the driver wants before a block-count write or a drain pause ends
  localparam int SETTLE = 4;

  // one pending driver word: a request, a block-count write or a drain pause
  typedef enum logic [1:0] {CMD_REQ, CMD_CFG, CMD_PAUSE} cmd_kind_t;

  typedef struct {
    cmd_kind_t                   kind;
    logic [bpr_pkg::OP_W-1:0]    op;
    logic [bpr_pkg::BLOCK_W-1:0] blk;
    logic [bpr_pkg::COUNT_W-1:0] count;
    int unsigned                 gap;
    bit                          gap_when_idle;  // gap cycles only count while the block is idle
  } pool_cmd_t;

  typedef struct {
    logic [bpr_pkg::STAT_W-1:0]  stat;
    logic [SLOT_W-1:0]           slot;
    logic                        wb_valid;
    logic [bpr_pkg::BLOCK_W-1:0] wb_block;
  } pool_answer_t;

  typedef enum logic [1:0] {DRV_FETCH, DRV_WAIT, DRV_DRIVE} drv_state_t;

  // dut ports, the driven inputs known from time zero
  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic [bpr_pkg::OP_W-1:0]    opcode = bpr_pkg::OP_LOOKUP;
  logic [bpr_pkg::BLOCK_W-1:0] block_num = '0;
  logic                        done;
  logic [bpr_pkg::STAT_W-1:0]  status;
  logic [SLOT_W-1:0]           slot;
  logic                        writeback_valid;
  logic [bpr_pkg::BLOCK_W-1:0] writeback_block;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [bpr_pkg::COUNT_W-1:0] cfg_data = '0;

  // shadow copy of the slot table and the block count
  logic                        shadow_used  [SLOTS];
  logic                        shadow_dirty [SLOTS];
  logic [TAG_W-1:0]            shadow_tag   [SLOTS];
  logic [AGE_W-1:0]            shadow_age   [SLOTS];
  logic [bpr_pkg::COUNT_W-1:0] shadow_limit;

  pool_cmd_t    pending_cmds [$];
  pool_answer_t pool_answers [$];

  // driver scratch
  pool_cmd_t   cur_cmd;
  drv_state_t  drv_state = DRV_FETCH;
  int unsigned gap_left;
  int unsigned idle_run;
  bit          next_start;
  bit          next_cfg;
  bit          burst_mode;

  // run statistics
  int n_req, n_alloc, n_evict, n_wb, n_oob, n_miss, n_cfg, n_pause;
  int mismatch_count;

  buffer_pool_replacement u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .block_num       (block_num),
    .done            (done),
    .status          (status),
    .slot            (slot),
    .writeback_valid (writeback_valid),
    .writeback_block (writeback_block),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // works out the answer to one accepted request and updates the shadow table
  task predict_pool_answer(input logic [bpr_pkg::OP_W-1:0] op,
                           input logic [bpr_pkg::BLOCK_W-1:0] blk);
    pool_answer_t ans;
    int           pick;
    ans.stat     = bpr_pkg::STAT_SUCCESS;
    ans.slot     = '0;
    ans.wb_valid = 1'b0;
    ans.wb_block = '0;
    n_req++;
    if ({1'b0, blk} >= shadow_limit) begin
      // bound test comes before any aging, nothing changes
      ans.stat = bpr_pkg::STAT_OOB;
      n_oob++;
    end else if (op == bpr_pkg::OP_ALLOCATE) begin
      n_alloc++;
      for (int i = 0; i < SLOTS; i++)
        if (shadow_used[i] && shadow_age[i] != AGE_TOP) shadow_age[i] = shadow_age[i] + 1'b1;
      // lowest free slot
      pick = -1;
      for (int i = SLOTS - 1; i >= 0; i--)
        if (!shadow_used[i]) pick = i;
      if (pick < 0) begin
        // table full: oldest slot goes, lowest index wins a tie
        pick = 0;
        for (int i = 1; i < SLOTS; i++)
          if (shadow_age[i] > shadow_age[pick]) pick = i;
        n_evict++;
        if (shadow_dirty[pick]) begin
          ans.wb_valid = 1'b1;
          ans.wb_block = shadow_tag[pick];
          n_wb++;
        end
      end
      shadow_used[pick]  = 1'b1;
      shadow_dirty[pick] = 1'b0;
      shadow_tag[pick]   = blk[TAG_W-1:0];
      shadow_age[pick]   = '0;
      ans.slot = pick[SLOT_W-1:0];
    end else begin
      // lookup, mark dirty and the unused code all search for the lowest match
      pick = -1;
      for (int i = SLOTS - 1; i >= 0; i--)
        if (shadow_used[i] && shadow_tag[i] == blk[TAG_W-1:0]) pick = i;
      if (pick < 0) begin
        ans.stat = bpr_pkg::STAT_NOT_FOUND;
        n_miss++;
      end else begin
        if (op == bpr_pkg::OP_MARK_DIRTY) shadow_dirty[pick] = 1'b1;
        ans.slot = pick[SLOT_W-1:0];
      end
    end
    pool_answers.push_back(ans);
  endtask

  // driver: one word at a time from the pending queue, gaps drawn per word
  always @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
      opcode    <= bpr_pkg::OP_LOOKUP;
      block_num <= '0;
      cfg_data  <= '0;
      drv_state = DRV_FETCH;
      idle_run  = 0;
      shadow_limit = bpr_pkg::COUNT_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        shadow_used[i]  = 1'b0;
        shadow_dirty[i] = 1'b0;
      end
    end else begin
      // a word taken at this edge updates the prediction first
      if (start && !busy) begin
        predict_pool_answer(opcode, block_num);
        drv_state = DRV_FETCH;
      end
      if (cfg_valid && cfg_ready) begin
        shadow_limit = cfg_data;
        n_cfg++;
        drv_state = DRV_FETCH;
      end
      if (done || busy) idle_run = 0;
      else if (idle_run < SETTLE) idle_run++;

      if (drv_state == DRV_FETCH && pending_cmds.size() != 0) begin
        cur_cmd   = pending_cmds.pop_front();
        gap_left  = cur_cmd.gap;
        drv_state = DRV_WAIT;
      end

      // count writes and pauses only start once the block has drained
      if (drv_state == DRV_WAIT) begin
        if (cur_cmd.kind == CMD_REQ || (pool_answers.size() == 0 && idle_run >= SETTLE)) begin
          if (gap_left != 0) begin
            if (!cur_cmd.gap_when_idle || !busy) gap_left--;
          end else begin
            drv_state = DRV_DRIVE;
          end
        end
      end

      // start and cfg_valid get a single assignment per edge so a held word never glitches
      next_start = 1'b0;
      next_cfg   = 1'b0;
      if (drv_state == DRV_DRIVE) begin
        case (cur_cmd.kind)
          CMD_REQ: begin
            next_start = 1'b1;
            opcode    <= cur_cmd.op;
            block_num <= cur_cmd.blk;
          end
          CMD_CFG: begin
            next_cfg = 1'b1;
            cfg_data <= cur_cmd.count;
          end
          default: begin
            n_pause++;
            drv_state = DRV_FETCH;
          end
        endcase
      end
      start     <= next_start;
      cfg_valid <= next_cfg;
    end
  end

  // monitor: each done strobe is one result word, checked against the oldest answer
  pool_answer_t exp_ans;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pool_answers.size() == 0) begin
        $display("%0t: result word with no request pending: status %0d slot %0d",
                 $time, status, slot);
        mismatch_count++;
      end else begin
        exp_ans = pool_answers.pop_front();
        if (status !== exp_ans.stat) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_ans.stat, status);
          mismatch_count++;
        end
        if (slot !== exp_ans.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, exp_ans.slot, slot);
          mismatch_count++;
        end
        if (writeback_valid !== exp_ans.wb_valid) begin
          $display("%0t: writeback_valid expected %0b actual %0b",
                   $time, exp_ans.wb_valid, writeback_valid);
          mismatch_count++;
        end
        if (writeback_block !== exp_ans.wb_block) begin
          $display("%0t: writeback_block expected %0d actual %0d",
                   $time, exp_ans.wb_block, writeback_block);
          mismatch_count++;
        end
      end
    end
  end

  task automatic push_cmd(input cmd_kind_t kind, input logic [bpr_pkg::OP_W-1:0] op,
                          input logic [bpr_pkg::BLOCK_W-1:0] blk,
                          input logic [bpr_pkg::COUNT_W-1:0] count);
    pool_cmd_t c;
    c.kind          = kind;
    c.op            = op;
    c.blk           = blk;
    c.count         = count;
    c.gap           = burst_mode ? 0 : $urandom_range(0, 18);
    c.gap_when_idle = burst_mode ? 1'b0 : 1'($urandom_range(0, 1));
    pending_cmds.push_back(c);
  endtask

  // random requests drawn mostly from a small set of hot block numbers so that
  // lookups hit, dirty marks land and the table fills and starts evicting
  task automatic random_phase(input logic [bpr_pkg::COUNT_W-1:0] count, input int n);
    logic [bpr_pkg::BLOCK_W-1:0] hot [48];
    int unsigned                 span;
    int unsigned                 pool_n;
    int unsigned                 pick;
    logic [bpr_pkg::OP_W-1:0]    op;
    logic [bpr_pkg::BLOCK_W-1:0] blk;
    span   = (count > 17'd65536) ? 65536 : count;
    pool_n = (span < 48) ? span : 20 + $urandom_range(0, 28);
    for (int i = 0; i < 48; i++)
      hot[i] = (span < 48) ? bpr_pkg::BLOCK_W'(i) :
                             bpr_pkg::BLOCK_W'($urandom_range(0, span - 1));
    if (span >= 48) begin
      hot[0] = '0;
      hot[1] = bpr_pkg::BLOCK_W'(span - 1);
    end
    for (int i = 0; i < n; i++) begin
      if (i % 16 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if (i == n / 2 && $urandom_range(0, 1) == 1) push_cmd(CMD_PAUSE, bpr_pkg::OP_LOOKUP, '0, '0);
      pick = $urandom_range(0, 99);
      if (pick < 40)      op = bpr_pkg::OP_ALLOCATE;
      else if (pick < 65) op = bpr_pkg::OP_MARK_DIRTY;
      else if (pick < 93) op = bpr_pkg::OP_LOOKUP;
      else                op = OP_UNUSED;
      if (span == 0 || $urandom_range(0, 19) == 0)
        blk = bpr_pkg::BLOCK_W'($urandom_range(0, 65535));
      else if (span < 65536 && $urandom_range(0, 19) == 0)
        blk = bpr_pkg::BLOCK_W'($urandom_range(span, 65535));
      else
        blk = hot[$urandom_range(0, pool_n - 1)];
      push_cmd(CMD_REQ, op, blk, '0);
    end
  endtask

  // stimulus, drain and final verdict
  logic [bpr_pkg::COUNT_W-1:0] mid_count;

  initial begin
    burst_mode = 1'b0;

    // directed part at the reset block count of 8192
    push_cmd(CMD_REQ, bpr_pkg::OP_LOOKUP,     16'd0,     '0);  // empty table misses
    push_cmd(CMD_REQ, bpr_pkg::OP_MARK_DIRTY, 16'd0,     '0);
    push_cmd(CMD_REQ, bpr_pkg::OP_ALLOCATE,   16'd8191,  '0);  // highest block in bound
    push_cmd(CMD_REQ, bpr_pkg::OP_ALLOCATE,   16'd8192,  '0);  // first block out of bound
    push_cmd(CMD_REQ, bpr_pkg::OP_ALLOCATE,   16'd0,     '0);
    push_cmd(CMD_REQ, OP_UNUSED,              16'd8191,  '0);  // unused code acts as a lookup
    push_cmd(CMD_REQ, OP_UNUSED,              16'd65535, '0);
    push_cmd(CMD_REQ, bpr_pkg::OP_MARK_DIRTY, 16'd8191,  '0);
    push_cmd(CMD_REQ, bpr_pkg::OP_LOOKUP,     16'd65535, '0);
    push_cmd(CMD_REQ, bpr_pkg::OP_MARK_DIRTY, 16'd8192,  '0);
    push_cmd(CMD_REQ, bpr_pkg::OP_ALLOCATE,   16'd8191,  '0);  // second copy of a buffered block
    push_cmd(CMD_REQ, bpr_pkg::OP_LOOKUP,     16'd8191,  '0);  // lowest copy found
    push_cmd(CMD_REQ, bpr_pkg::OP_MARK_DIRTY, 16'd0,     '0);
    push_cmd(CMD_REQ, bpr_pkg::OP_LOOKUP,     16'd4097,  '0);
    // sender holds off until every answer is back
    push_cmd(CMD_PAUSE, bpr_pkg::OP_LOOKUP, '0, '0);

    random_phase(bpr_pkg::COUNT_RESET, 90);
    push_cmd(CMD_CFG, bpr_pkg::OP_LOOKUP, '0, 17'd1);          // only block 0 in bound
    random_phase(17'd1, 40);
    push_cmd(CMD_CFG, bpr_pkg::OP_LOOKUP, '0, 17'd0);          // every block out of bound
    random_phase(17'd0, 10);
    push_cmd(CMD_CFG, bpr_pkg::OP_LOOKUP, '0, 17'h1FFFF);      // count above the block range
    random_phase(17'h1FFFF, 90);
    push_cmd(CMD_CFG, bpr_pkg::OP_LOOKUP, '0, 17'd65536);
    random_phase(17'd65536, 50);
    push_cmd(CMD_CFG, bpr_pkg::OP_LOOKUP, '0, 17'd65535);      // only the top block out of bound
    random_phase(17'd65535, 40);
    mid_count = bpr_pkg::COUNT_W'($urandom_range(2, 200));
    push_cmd(CMD_CFG, bpr_pkg::OP_LOOKUP, '0, mid_count);
    random_phase(mid_count, 90);
    push_cmd(CMD_CFG, bpr_pkg::OP_LOOKUP, '0, bpr_pkg::COUNT_RESET);
    random_phase(bpr_pkg::COUNT_RESET, 40);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // wait for the last word to be taken and its answer to come back
    do begin
      @(posedge clk);
      #1;
    end while (!(drv_state == DRV_FETCH && pending_cmds.size() == 0 && !start &&
                 !cfg_valid && !busy && pool_answers.size() == 0));
    repeat (SLOTS + 8) @(posedge clk);

    if (pool_answers.size() != 0) begin
      $display("%0t: %0d answers never came back", $time, pool_answers.size());
      mismatch_count++;
    end
    $display("run covered %0d requests: %0d allocations, %0d evictions, %0d dirty writebacks",
             n_req, n_alloc, n_evict, n_wb);
    $display("%0d out-of-bound and %0d missing-block answers, %0d block-count writes, %0d drains",
             n_oob, n_miss, n_cfg, n_pause);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/bpr_pkg.sv
hw/rtl/bpr_cell.sv
hw/rtl/buffer_pool_replacement.sv
test/tb_buffer_pool_replacement.sv
